[src/nps_pkg.sv]
// nps_pkg: shared codes and widths for the nearest plane signed distance block
// holds command, status and register index codes; no dependencies
package nps_pkg;

    // normal components are Q2.14
    localparam int NRM_BITS = 16;
    // widths fixed by the request and result fields
    localparam int SLOT_BITS = 10;
    localparam int INDEX_BITS = 10;
    localparam int COUNT_BITS = 11;
    localparam int LIMIT_BITS = 31;
    localparam int DIST_BITS = 32;
    // rounding of the Q.30 dot product down to Q16.16
    localparam int ROUND_SHIFT = 14;
    localparam int ROUND_HALF = 8192;

    typedef enum logic [0:0] {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_VALID  = 2'd0,
        STATUS_REJECT = 2'd1,
        STATUS_EMPTY  = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        REG_PLANE_COUNT    = 1'b0,
        REG_DISTANCE_LIMIT = 1'b1
    } reg_index_t;

endpackage

[src/nearest_plane_signed_distance.sv]
// nearest_plane_signed_distance: top level of the nearest tangent plane distance block
// depends on nps_pkg and nps_ram (one memory holding origins and normals)
//
// Usage: a request is taken on a clock edge with start high and busy low.
// cmd = load writes origin pos_* and unit normal dir_* into entry slot; the
// block stays idle and gives no result. Loads to a slot at or beyond
// MAX_PLANES are dropped.
// cmd = query searches entries 0 .. plane_count-1 for the origin nearest to
// pos_* by squared distance (lowest index on a tie), then returns the signed
// projection of the offset onto that entry's normal. The result appears on
// status, signed_distance and nearest_index for exactly one cycle with done
// high; the receiver cannot stall it.
// A query scans plane_count entries (count clamped to MAX_PLANES); the scan
// reads one memory entry per cycle through a five-stage squared-distance
// pipeline, then one more read of the winning entry feeds the projection.
// An empty table answers in the cycle after the request. busy is high for
// the whole query and drops in the cycle with done, so the next request can
// be taken there.
// Configuration (cfg_write, cfg_index, cfg_data) takes effect at once; the user
// must only write it while the block is idle; the block does not enforce this.
// Reset clears control state, plane_count to 0 and distance_limit to 1.0;
// the plane memory is not cleared and entries must be loaded before use.
module nearest_plane_signed_distance #(
    parameter int MAX_PLANES = 1024,
    parameter int COORD_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  nps_pkg::reg_index_t                 cfg_index,
    input  logic [nps_pkg::LIMIT_BITS-1:0]      cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  nps_pkg::cmd_t                       cmd,
    input  logic [nps_pkg::SLOT_BITS-1:0]       slot,
    input  logic signed [COORD_BITS-1:0]        pos_x,
    input  logic signed [COORD_BITS-1:0]        pos_y,
    input  logic signed [COORD_BITS-1:0]        pos_z,
    input  logic signed [nps_pkg::NRM_BITS-1:0] dir_x,
    input  logic signed [nps_pkg::NRM_BITS-1:0] dir_y,
    input  logic signed [nps_pkg::NRM_BITS-1:0] dir_z,
    output logic                                done,
    output nps_pkg::status_t                    status,
    output logic signed [nps_pkg::DIST_BITS-1:0] signed_distance,
    output logic [nps_pkg::INDEX_BITS-1:0]      nearest_index
);

    import nps_pkg::*;

    localparam int AW   = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int CW   = $clog2(MAX_PLANES + 1);
    localparam int RW   = 3 * COORD_BITS + 3 * NRM_BITS;
    // difference and its magnitude
    localparam int MW   = COORD_BITS + 1;
    // squaring split into halves
    localparam int H    = (MW + 1) / 2;
    localparam int HW   = MW - H;
    localparam int SQW  = 2 * MW;
    localparam int SUMW = SQW + 2;
    // projection
    localparam int PW   = MW + NRM_BITS;
    localparam int DOTW = PW + 2;
    localparam int RNDW = DOTW - ROUND_SHIFT;
    localparam int CMPW = (RNDW > LIMIT_BITS) ? RNDW : LIMIT_BITS;
    // memory word layout: origin x, y, z then normal x, y, z
    localparam int NZ_LO = 0;
    localparam int NY_LO = NRM_BITS;
    localparam int NX_LO = 2 * NRM_BITS;
    localparam int OZ_LO = 3 * NRM_BITS;
    localparam int OY_LO = OZ_LO + COORD_BITS;
    localparam int OX_LO = OY_LO + COORD_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_P_ADDR,
        ST_P_DIFF,
        ST_P_MUL,
        ST_P_SUM,
        ST_P_RND,
        ST_P_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          scan_cnt_reg, scan_cnt_next;
    logic [CW-1:0]          n_reg, n_next;
    logic [CW-1:0]          n_clamp;
    logic [COUNT_BITS-1:0]  plane_count_reg;
    logic [LIMIT_BITS-1:0]  distance_limit_reg;
    logic [4:0]             vld_reg;
    logic                   best_vld_reg;
    logic                   done_reg;
    status_t                status_reg;
    logic signed [DIST_BITS-1:0] dist_reg;
    logic [INDEX_BITS-1:0]  index_reg;

    logic                   accept;
    logic                   load_req;
    logic                   query_req;
    logic                   issuing;
    logic                   best_upd;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [RW-1:0]          ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [RW-1:0]          ram_rdata;

    // query point and per-axis views of the memory word
    logic signed [COORD_BITS-1:0] qry_reg [3];
    logic signed [COORD_BITS-1:0] org    [3];
    logic signed [NRM_BITS-1:0]   nrm    [3];

    // scan pipeline payload
    logic [AW-1:0]          idx_reg [5];
    logic [MW-1:0]          mag_reg [3];
    logic [2*H-1:0]         ll_reg  [3];
    logic [MW-1:0]          hl_reg  [3];
    logic [2*HW-1:0]        hh_reg  [3];
    logic [SQW-1:0]         sq_reg  [3];
    logic [SUMW-1:0]        sum_reg;
    logic [SUMW-1:0]        best_dist_reg;
    logic [AW-1:0]          best_idx_reg;

    // projection payload
    logic signed [MW-1:0]   pdiff_reg [3];
    logic signed [PW-1:0]   prod_reg  [3];
    logic signed [DOTW-1:0] dot_reg;
    logic signed [DOTW-1:0] dot_rnd;
    logic signed [RNDW-1:0] rnd_reg;
    logic [RNDW-1:0]        rnd_mag;
    logic                   reject;

    // request decode
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign load_req  = accept && (cmd == CMD_LOAD);
    assign query_req = accept && (cmd == CMD_QUERY);
    assign n_clamp   = (32'(plane_count_reg) > MAX_PLANES) ? CW'(MAX_PLANES)
                                                           : CW'(plane_count_reg);
    assign issuing   = (state_reg == ST_SCAN) && (scan_cnt_reg < n_reg);

    // plane memory; loads only happen while idle, so they never meet a scan read
    assign ram_we    = load_req && (32'(slot) < MAX_PLANES);
    assign ram_waddr = AW'(slot);
    assign ram_wdata = {COORD_BITS'(pos_x), COORD_BITS'(pos_y), COORD_BITS'(pos_z),
                        dir_x, dir_y, dir_z};
    assign ram_raddr = (state_reg == ST_SCAN) ? scan_cnt_reg[AW-1:0] : best_idx_reg;

    nps_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_PLANES)
    ) u_plane_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign org[0] = ram_rdata[OX_LO +: COORD_BITS];
    assign org[1] = ram_rdata[OY_LO +: COORD_BITS];
    assign org[2] = ram_rdata[OZ_LO +: COORD_BITS];
    assign nrm[0] = ram_rdata[NX_LO +: NRM_BITS];
    assign nrm[1] = ram_rdata[NY_LO +: NRM_BITS];
    assign nrm[2] = ram_rdata[NZ_LO +: NRM_BITS];

    // running minimum; strict compare keeps the lowest index on a tie
    assign best_upd = vld_reg[4] && (!best_vld_reg || (sum_reg < best_dist_reg));

    // rounding and rejection test of the projection
    assign dot_rnd = dot_reg + DOTW'(ROUND_HALF);
    assign rnd_mag = rnd_reg[RNDW-1] ? RNDW'(-rnd_reg) : RNDW'(rnd_reg);
    assign reject  = CMPW'(rnd_mag) >= CMPW'(distance_limit_reg);

    // next state
    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        n_next        = n_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_req && (n_clamp != '0))
                begin
                    state_next    = ST_SCAN;
                    scan_cnt_next = '0;
                    n_next        = n_clamp;
                end
            end
            ST_SCAN:
            begin
                if (issuing)
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                else if (vld_reg == '0)
                begin
                    state_next = ST_P_ADDR;
                end
            end
            ST_P_ADDR: state_next = ST_P_DIFF;
            ST_P_DIFF: state_next = ST_P_MUL;
            ST_P_MUL:  state_next = ST_P_SUM;
            ST_P_SUM:  state_next = ST_P_RND;
            ST_P_RND:  state_next = ST_P_OUT;
            ST_P_OUT:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control state, configuration and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            scan_cnt_reg       <= '0;
            n_reg              <= '0;
            plane_count_reg    <= '0;
            distance_limit_reg <= LIMIT_BITS'(65536);
            vld_reg            <= '0;
            best_vld_reg       <= 1'b0;
            done_reg           <= 1'b0;
            status_reg         <= STATUS_VALID;
            dist_reg           <= '0;
            index_reg          <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            n_reg        <= n_next;
            vld_reg      <= {vld_reg[3:0], issuing};
            done_reg     <= 1'b0;

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_PLANE_COUNT:    plane_count_reg    <= cfg_data[COUNT_BITS-1:0];
                    REG_DISTANCE_LIMIT: distance_limit_reg <= cfg_data;
                    default:            plane_count_reg    <= plane_count_reg;
                endcase
            end

            if (state_reg == ST_IDLE)
            begin
                best_vld_reg <= 1'b0;
            end
            else if (best_upd)
            begin
                best_vld_reg <= 1'b1;
            end

            // empty table answers at once
            if (query_req && (n_clamp == '0))
            begin
                done_reg   <= 1'b1;
                status_reg <= STATUS_EMPTY;
                dist_reg   <= '0;
                index_reg  <= '0;
            end
            else if (state_reg == ST_P_OUT)
            begin
                done_reg   <= 1'b1;
                status_reg <= reject ? STATUS_REJECT : STATUS_VALID;
                dist_reg   <= reject ? '0 : DIST_BITS'(rnd_reg);
                index_reg  <= INDEX_BITS'(best_idx_reg);
            end
        end
    end

    // datapath: scan pipeline and projection
    always_ff @(posedge clk)
    begin
        if (query_req)
        begin
            qry_reg[0] <= pos_x;
            qry_reg[1] <= pos_y;
            qry_reg[2] <= pos_z;
        end

        idx_reg[0] <= scan_cnt_reg[AW-1:0];
        for (int k = 1; k < 5; k++)
        begin
            idx_reg[k] <= idx_reg[k-1];
        end

        for (int a = 0; a < 3; a++)
        begin
            // magnitude of the offset, then partial products, then the square
            mag_reg[a] <= (MW'(qry_reg[a]) < MW'(org[a]))
                          ? MW'(MW'(org[a]) - MW'(qry_reg[a]))
                          : MW'(MW'(qry_reg[a]) - MW'(org[a]));
            ll_reg[a]  <= (2*H)'(mag_reg[a][H-1:0]) * (2*H)'(mag_reg[a][H-1:0]);
            hl_reg[a]  <= MW'(mag_reg[a][MW-1:H]) * MW'(mag_reg[a][H-1:0]);
            hh_reg[a]  <= (2*HW)'(mag_reg[a][MW-1:H]) * (2*HW)'(mag_reg[a][MW-1:H]);
            sq_reg[a]  <= (SQW'(hh_reg[a]) << (2*H)) + (SQW'(hl_reg[a]) << (H+1))
                          + SQW'(ll_reg[a]);

            // projection terms of the winning entry
            pdiff_reg[a] <= MW'(qry_reg[a]) - MW'(org[a]);
            prod_reg[a]  <= PW'(pdiff_reg[a]) * PW'(nrm[a]);
        end

        sum_reg <= SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);
        if (best_upd)
        begin
            best_dist_reg <= sum_reg;
            best_idx_reg  <= idx_reg[4];
        end

        dot_reg <= DOTW'(prod_reg[0]) + DOTW'(prod_reg[1]) + DOTW'(prod_reg[2]);
        rnd_reg <= dot_rnd[DOTW-1:ROUND_SHIFT];
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign signed_distance = dist_reg;
    assign nearest_index   = index_reg;

    // scan pipeline only carries entries during a scan
    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg != '0) |-> (state_reg == ST_SCAN))
        else $error("scan pipeline active outside a scan");

    // the projection always reads an entry that the scan searched
    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_P_ADDR) |-> (best_vld_reg && (CW'(best_idx_reg) < n_reg)))
        else $error("projection of an entry outside the searched range");

    // a load never starts a query sequence
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == CMD_LOAD)) |=> (state_reg == ST_IDLE))
        else $error("load left the block busy");

    // only a valid answer carries a distance
    a_zero_unless_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STATUS_VALID)) |-> (signed_distance == '0))
        else $error("distance reported with a non-valid status");

    // the scan counter never runs past the clamped count
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg <= n_reg))
        else $error("scan counter beyond plane count");

endmodule

[src/nps_ram.sv]
// nps_ram: generic single-port-write, single-port-read synchronous memory
// registered read data; no dependencies
module nps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
